@@ rtl/p2sa_pkg.sv @@
// ============================================================================
// p2sa_pkg
// Shared types and constants for the 2D similarity alignment block.
// ============================================================================
`default_nettype none

package p2sa_pkg;

    // Fixed field and arithmetic widths.
    localparam int COORD_W    = 16;   // Q7.8 coordinate
    localparam int IN_DATA_W  = 64;   // four coordinates
    localparam int OUT_DATA_W = 32;   // two coordinates
    localparam int SUM_W      = 40;   // accumulated sums
    localparam int CD_W       = 31;   // normalised cross and dot magnitudes
    localparam int RAD_W      = 64;   // radicand of the square root unit
    localparam int ROOT_W     = 32;   // square root result
    localparam int DIV_NUM_W  = 49;   // dividend of the divider
    localparam int TRIG_W     = 18;   // signed Q1.16 cos and sin
    localparam int TRIGQ_W    = 17;   // unsigned divider result for cos and sin
    localparam int SCL_W      = 24;   // unsigned Q8.16 scale
    localparam int ITER_W     = 6;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 49;
    localparam int NORM_SHIFT = 26;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_NORM,
        S_SQ,
        S_GO,
        S_WAIT,
        S_FIN,
        S_RD,
        S_M1,
        S_M2,
        S_OUT,
        S_DONE
    } t_state;

    // Operations of the shared iterative unit, in the order they are run.
    typedef enum logic [2:0] {
        OP_SQ_R,
        OP_DV_COS,
        OP_DV_SIN,
        OP_SQ_REF,
        OP_SQ_SHP,
        OP_DV_SCL
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_acc;
        logic mul;
        logic norm;
        logic sq;
        logic go;
        t_op  op;
        logic fin;
        logic rd;
        logic m1;
        logic m2;
        logic load_out;
        logic clr;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic unit_done;
        logic last_idx;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ rtl/p2sa_ram.sv @@
// ============================================================================
// p2sa_ram
// Generic simple dual port RAM with one write port and a registered read.
// ============================================================================
`default_nettype none

module p2sa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/p2sa_ctrl.sv @@
// ============================================================================
// p2sa_ctrl
// Sequencer: loading, rotation and scale computation, then point emission.
// ============================================================================
`default_nettype none

module p2sa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_last,
    output logic                   o_in_ready,
    input  wire p2sa_pkg::t_dp_sts i_sts,
    output p2sa_pkg::t_dp_cmd      o_cmd
);

    import p2sa_pkg::*;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_SQ_R;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_last  <= n_last;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_last  = r_last;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_last  = i_in_last;
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = r_last ? S_ACC : S_IDLE;
            S_ACC:  n_state = S_NORM;
            S_NORM: n_state = S_SQ;
            S_SQ: begin
                n_op    = OP_SQ_R;
                n_state = S_GO;
            end
            S_GO:   n_state = S_WAIT;
            S_WAIT: begin
                if (i_sts.unit_done) begin
                    case (r_op)
                        OP_SQ_R:   begin n_op = OP_DV_COS; n_state = S_GO; end
                        OP_DV_COS: begin n_op = OP_DV_SIN; n_state = S_GO; end
                        OP_DV_SIN: begin n_op = OP_SQ_REF; n_state = S_GO; end
                        OP_SQ_REF: begin n_op = OP_SQ_SHP; n_state = S_GO; end
                        OP_SQ_SHP: begin n_op = OP_DV_SCL; n_state = S_GO; end
                        default:   n_state = S_FIN;
                    endcase
                end
            end
            S_FIN:  n_state = S_RD;
            S_RD:   n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_OUT;
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.last_idx ? S_DONE : S_RD;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = r_op;
        o_in_ready     = (r_state == S_IDLE);
        o_cmd.in_acc   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.norm     = (r_state == S_NORM);
        o_cmd.sq       = (r_state == S_SQ);
        o_cmd.go       = (r_state == S_GO);
        o_cmd.fin      = (r_state == S_FIN);
        o_cmd.rd       = (r_state == S_RD);
        o_cmd.m1       = (r_state == S_M1);
        o_cmd.m2       = (r_state == S_M2);
        o_cmd.load_out = (r_state == S_OUT) && i_sts.out_free;
        o_cmd.clr      = (r_state == S_DONE);
    end

endmodule

`default_nettype wire

@@ rtl/p2sa_dp.sv @@
// ============================================================================
// p2sa_dp
// Datapath: sums, point store, shared square root and divider, emit pipeline.
// ============================================================================
`default_nettype none

module p2sa_dp #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire p2sa_pkg::t_dp_cmd                    i_cmd,
    output p2sa_pkg::t_dp_sts                         o_sts,
    input  wire logic                                 i_cfg_wen,
    input  wire logic                                 i_cfg_wdata,
    input  wire logic [p2sa_pkg::IN_DATA_W-1:0]       i_in_data,
    output logic      [p2sa_pkg::OUT_DATA_W-1:0]      o_out_data,
    output logic                                      o_out_valid,
    output logic                                      o_out_last,
    input  wire logic                                 i_out_ready
);

    import p2sa_pkg::*;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = $clog2(MAX_POINTS);

    // Rounds a value with 40 fractional bits to Q7.8, half away from zero.
    function automatic logic [COORD_W-1:0] round_q78(input logic signed [59:0] p);
        logic [59:0] mag;
        logic [59:0] sum;
        logic [27:0] m;
        logic [15:0] res;
        mag = p[59] ? (~p + 60'd1) : p;
        sum = mag + (60'd1 << 31);
        m   = sum[59:32];
        if (p[59]) begin
            res = (m > 28'd32768) ? 16'h8000 : 16'(~m + 28'd1);
        end else begin
            res = (m > 28'd32767) ? 16'h7FFF : m[15:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic r_scl_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl_en <= 1'b1;
        end else if (i_cfg_wen) begin
            r_scl_en <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Loading: store point, products, accumulation
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] r_sx, r_sy, r_rx, r_ry;
    logic                      r_keep, r_prod_vld;
    logic [CNT_W-1:0]          r_cnt, r_idx;
    logic signed [32:0]        r_pc, r_pd;
    logic [31:0]               r_pn_s, r_pn_r;
    logic [SUM_W-1:0]          r_cross, r_dot, r_shn, r_refn;
    logic                      keep_now;
    logic signed [31:0]        p_xry, p_yrx, p_xrx, p_yry, p_xx, p_yy, p_rxx, p_ryy;

    assign keep_now = (r_cnt < CNT_W'(MAX_POINTS));

    assign p_xry = r_sx * r_ry;
    assign p_yrx = r_sy * r_rx;
    assign p_xrx = r_sx * r_rx;
    assign p_yry = r_sy * r_ry;
    assign p_xx  = r_sx * r_sx;
    assign p_yy  = r_sy * r_sy;
    assign p_rxx = r_rx * r_rx;
    assign p_ryy = r_ry * r_ry;

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_acc) begin
            r_sx <= i_in_data[15:0];
            r_sy <= i_in_data[31:16];
            r_rx <= i_in_data[47:32];
            r_ry <= i_in_data[63:48];
        end
        if (i_cmd.mul) begin
            r_pc   <= 33'(p_xry) - 33'(p_yrx);
            r_pd   <= 33'(p_xrx) + 33'(p_yry);
            r_pn_s <= unsigned'(p_xx) + unsigned'(p_yy);
            r_pn_r <= unsigned'(p_rxx) + unsigned'(p_ryy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep     <= 1'b0;
            r_prod_vld <= 1'b0;
            r_cnt      <= '0;
            r_cross    <= '0;
            r_dot      <= '0;
            r_shn      <= '0;
            r_refn     <= '0;
        end else begin
            r_prod_vld <= i_cmd.mul && r_keep;
            if (i_cmd.in_acc) begin
                r_keep <= keep_now;
                if (keep_now) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            if (r_prod_vld) begin
                r_cross <= r_cross + SUM_W'(r_pc);
                r_dot   <= r_dot + SUM_W'(r_pd);
                r_shn   <= r_shn + SUM_W'(r_pn_s);
                r_refn  <= r_refn + SUM_W'(r_pn_r);
            end
            if (i_cmd.clr) begin
                r_cnt   <= '0;
                r_cross <= '0;
                r_dot   <= '0;
                r_shn   <= '0;
                r_refn  <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Normalisation of the cross and dot magnitudes below 2^31
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] c_mag, d_mag, cd_or, c_sh, d_sh;
    logic [3:0]       nrm_sh;
    logic [CD_W-1:0]  r_c, r_d;
    logic [61:0]      p_cc, p_dd;
    logic [62:0]      r_cd2;

    assign c_mag = r_cross[SUM_W-1] ? (~r_cross + SUM_W'(1)) : r_cross;
    assign d_mag = r_dot[SUM_W-1] ? (~r_dot + SUM_W'(1)) : r_dot;
    assign cd_or = c_mag | d_mag;

    always_comb begin
        nrm_sh = 4'd0;
        for (int i = CD_W; i < SUM_W; i++) begin
            if (cd_or[i]) begin
                nrm_sh = 4'(i - CD_W + 1);
            end
        end
    end

    assign c_sh = c_mag >> nrm_sh;
    assign d_sh = d_mag >> nrm_sh;
    assign p_cc = r_c * r_c;
    assign p_dd = r_d * r_d;

    always_ff @(posedge i_clk) begin
        if (i_cmd.norm) begin
            r_c <= c_sh[CD_W-1:0];
            r_d <= d_sh[CD_W-1:0];
        end
        if (i_cmd.sq) begin
            r_cd2 <= 63'(p_cc) + 63'(p_dd);
        end
    end

    // ------------------------------------------------------------------
    // Shared iterative unit: digit-by-digit square root and restoring divider
    // ------------------------------------------------------------------
    logic              r_busy;
    logic [ITER_W-1:0] r_iter;
    t_op               r_uop;
    logic [RAD_W-1:0]  r_sq_val;
    logic [35:0]       r_sq_rem;
    logic [ROOT_W-1:0] r_sq_root;
    logic [DIV_NUM_W-1:0] r_dv_num, r_dv_quo;
    logic [31:0]       r_dv_rem, r_dv_dvs;
    logic [ROOT_W-1:0] r_r, r_sr, r_ss;
    logic [TRIGQ_W-1:0] r_cos_q, r_sin_q;
    logic [SCL_W-1:0]  r_scl_q;

    logic [35:0]       sq_rem_sh, sq_trial, sq_rem_n;
    logic [ROOT_W-1:0] sq_root_n;
    logic [32:0]       dv_rem_sh;
    logic [31:0]       dv_rem_n;
    logic [DIV_NUM_W-1:0] dv_quo_n;
    logic              unit_done;
    logic              go_sqrt;
    logic [RAD_W-1:0]  sq_start_val;
    logic [DIV_NUM_W-1:0] dv_start_num;
    logic [31:0]       dv_start_dvs;

    assign sq_rem_sh = {r_sq_rem[33:0], r_sq_val[RAD_W-1 -: 2]};
    assign sq_trial  = {2'b00, r_sq_root, 2'b01};

    always_comb begin
        if (sq_rem_sh >= sq_trial) begin
            sq_rem_n  = sq_rem_sh - sq_trial;
            sq_root_n = {r_sq_root[ROOT_W-2:0], 1'b1};
        end else begin
            sq_rem_n  = sq_rem_sh;
            sq_root_n = {r_sq_root[ROOT_W-2:0], 1'b0};
        end
    end

    assign dv_rem_sh = {r_dv_rem, r_dv_num[DIV_NUM_W-1]};

    always_comb begin
        if (dv_rem_sh >= {1'b0, r_dv_dvs}) begin
            dv_rem_n = 32'(dv_rem_sh - {1'b0, r_dv_dvs});
            dv_quo_n = {r_dv_quo[DIV_NUM_W-2:0], 1'b1};
        end else begin
            dv_rem_n = dv_rem_sh[31:0];
            dv_quo_n = {r_dv_quo[DIV_NUM_W-2:0], 1'b0};
        end
    end

    always_comb begin
        go_sqrt      = 1'b0;
        sq_start_val = '0;
        dv_start_num = '0;
        dv_start_dvs = r_r;
        case (i_cmd.op)
            OP_SQ_R: begin
                go_sqrt      = 1'b1;
                sq_start_val = {1'b0, r_cd2};
            end
            OP_SQ_REF: begin
                go_sqrt      = 1'b1;
                sq_start_val = {r_refn[RAD_W-NORM_SHIFT-1:0], {NORM_SHIFT{1'b0}}};
            end
            OP_SQ_SHP: begin
                go_sqrt      = 1'b1;
                sq_start_val = {r_shn[RAD_W-NORM_SHIFT-1:0], {NORM_SHIFT{1'b0}}};
            end
            OP_DV_COS: dv_start_num = DIV_NUM_W'({r_d, 16'h0000}) + DIV_NUM_W'(r_r >> 1);
            OP_DV_SIN: dv_start_num = DIV_NUM_W'({r_c, 16'h0000}) + DIV_NUM_W'(r_r >> 1);
            OP_DV_SCL: begin
                dv_start_num = DIV_NUM_W'({r_sr, 16'h0000}) + DIV_NUM_W'(r_ss >> 1);
                dv_start_dvs = r_ss;
            end
            default: go_sqrt = 1'b0;
        endcase
    end

    assign unit_done = r_busy && (r_iter == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
            r_uop  <= OP_SQ_R;
        end else if (i_cmd.go) begin
            r_busy <= 1'b1;
            r_uop  <= i_cmd.op;
            r_iter <= go_sqrt ? ITER_W'(SQRT_STEPS - 1) : ITER_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_iter <= r_iter - ITER_W'(1);
            if (r_iter == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.go) begin
            r_sq_val  <= sq_start_val;
            r_sq_rem  <= '0;
            r_sq_root <= '0;
            r_dv_num  <= dv_start_num;
            r_dv_dvs  <= dv_start_dvs;
            r_dv_rem  <= '0;
            r_dv_quo  <= '0;
        end else if (r_busy) begin
            r_sq_val  <= {r_sq_val[RAD_W-3:0], 2'b00};
            r_sq_rem  <= sq_rem_n;
            r_sq_root <= sq_root_n;
            r_dv_num  <= {r_dv_num[DIV_NUM_W-2:0], 1'b0};
            r_dv_rem  <= dv_rem_n;
            r_dv_quo  <= dv_quo_n;
        end
        if (unit_done) begin
            case (r_uop)
                OP_SQ_R:   r_r     <= sq_root_n;
                OP_SQ_REF: r_sr    <= sq_root_n;
                OP_SQ_SHP: r_ss    <= sq_root_n;
                OP_DV_COS: r_cos_q <= dv_quo_n[TRIGQ_W-1:0];
                OP_DV_SIN: r_sin_q <= dv_quo_n[TRIGQ_W-1:0];
                OP_DV_SCL: r_scl_q <= (|dv_quo_n[DIV_NUM_W-1:SCL_W]) ? {SCL_W{1'b1}}
                                                                      : dv_quo_n[SCL_W-1:0];
                default:   r_r     <= r_r;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Final rotation and scale with the special cases
    // ------------------------------------------------------------------
    logic signed [TRIG_W-1:0] r_cs, r_sn;
    logic [SCL_W-1:0]         r_sc;
    logic signed [TRIG_W-1:0] sin_pos;
    logic                     sums_zero;

    assign sin_pos   = signed'({1'b0, r_sin_q});
    assign sums_zero = (r_cross == '0) && (r_dot == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            if (sums_zero) begin
                r_cs <= TRIG_W'(65536);
                r_sn <= '0;
            end else begin
                r_cs <= signed'({1'b0, r_cos_q});
                r_sn <= (r_cross[SUM_W-1] ^ r_dot[SUM_W-1]) ? -sin_pos : sin_pos;
            end
            if (!r_scl_en) begin
                r_sc <= SCL_W'(65536);
            end else if (r_shn == '0) begin
                r_sc <= '0;
            end else begin
                r_sc <= r_scl_q;
            end
        end
    end

    // ------------------------------------------------------------------
    // Point store and emit pipeline
    // ------------------------------------------------------------------
    logic [OUT_DATA_W-1:0]     ram_rdata;
    logic signed [COORD_W-1:0] e_x, e_y;
    logic signed [33:0]        p_cx, p_sy, p_sx, p_cy;
    logic signed [34:0]        r_tx, r_ty;
    logic signed [59:0]        r_px, r_py;
    logic signed [SCL_W:0]     sc_s;
    logic [COORD_W-1:0]        r_out_x, r_out_y;
    logic                      r_out_vld, r_out_last;

    p2sa_ram #(
        .WIDTH (OUT_DATA_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.in_acc && keep_now),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (i_in_data[OUT_DATA_W-1:0]),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign e_x  = ram_rdata[15:0];
    assign e_y  = ram_rdata[31:16];
    assign p_cx = r_cs * e_x;
    assign p_sy = r_sn * e_y;
    assign p_sx = r_sn * e_x;
    assign p_cy = r_cs * e_y;
    assign sc_s = signed'({1'b0, r_sc});

    always_ff @(posedge i_clk) begin
        if (i_cmd.m1) begin
            r_tx <= 35'(p_cx) - 35'(p_sy);
            r_ty <= 35'(p_sx) + 35'(p_cy);
        end
        if (i_cmd.m2) begin
            r_px <= r_tx * sc_s;
            r_py <= r_ty * sc_s;
        end
        if (i_cmd.load_out) begin
            r_out_x    <= round_q78(r_px);
            r_out_y    <= round_q78(r_py);
            r_out_last <= o_sts.last_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
                r_idx     <= r_idx + CNT_W'(1);
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.clr) begin
                r_idx <= '0;
            end
        end
    end

    assign o_sts.unit_done = unit_done;
    assign o_sts.last_idx  = ((r_idx + CNT_W'(1)) == r_cnt);
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    assign o_out_data  = {r_out_y, r_out_x};
    assign o_out_valid = r_out_vld;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

@@ rtl/procrustes_2d_similarity_align.sv @@
// ============================================================================
// procrustes_2d_similarity_align
// Aligns one 2D landmark shape onto a reference by rotation and scaling.
// ============================================================================
// Use: each input item on the s_axis channel carries one landmark pair, the
// shape point and its reference point, all Q7.8. The shape point is stored
// and the cross, dot and squared norm sums are accumulated. The item marked
// with s_axis_tlast closes the shape: the rotation and the norm ratio scale
// are then worked out and every stored point is sent on the m_axis channel,
// rotated and scaled, with m_axis_tlast on the final point.
// Input: a landmark pair is taken, then its products are formed while no new
// pair is taken; the accumulation then overlaps with taking the next pair.
// After the closing pair the shared square root and divider unit runs six
// operations in turn (three roots of 32 steps, three divisions of 49 steps),
// and each point then passes through the store read, rotation multiply, scale
// multiply and rounding into the output register.
// Pairs beyond MAX_POINTS are dropped but a closing mark still takes effect.
// The receiver may stall at will: the output register holds its item and the
// emission waits, and no new pair is taken until the last point is loaded out.
// Reset empties the point store logically, clears the sums and sets scaling
// on; the configuration write enable may be used only while the block idles.
// ============================================================================
`default_nettype none

module procrustes_2d_similarity_align #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Landmark pairs in.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // shape_x, shape_y, ref_x, ref_y
    input  wire logic        s_axis_tlast,   // last_point
    // Aligned points out.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // aligned_x, aligned_y
    output logic             m_axis_tlast,   // last_out
    // Configuration: scale_enable.
    input  wire logic        i_cfg_wen,
    input  wire logic        i_cfg_wdata
);

    import p2sa_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // The controller decides when a pair is taken and sequences the maths.
    p2sa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the sums, the point store and the output register.
    p2sa_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .o_out_data  (m_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .o_out_last  (m_axis_tlast),
        .i_out_ready (m_axis_tready)
    );

endmodule

`default_nettype wire

@@ rtl/p2sa_chk.sv @@
// ============================================================================
// p2sa_chk
// Port level checks of the alignment block, bound to the top level.
// ============================================================================
`default_nettype none

module p2sa_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // Nothing is offered out in the cycle after reset.
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid straight after reset");

    // A pair taken is followed by a cycle in which no pair is taken.
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken in two consecutive cycles");

    // While a point other than the last of a shape waits, input is closed.
    a_emit_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input open during emission");

    // A stalled output item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output item changed");

endmodule

bind procrustes_2d_similarity_align p2sa_chk u_p2sa_chk (.*);

`default_nettype wire
